// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file rtl/ssl_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also runs through reset.
`define ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ssl_pkg.sv
package ssl_pkg;

  localparam int CHANNELS_DEF = 3;
  localparam int OUT_LEDS     = 3;

  localparam logic [7:0] STAR_BYTE  = 8'h2A;
  localparam logic [7:0] DIGIT_BASE = 8'd48;
  localparam logic [7:0] MODE_ON    = 8'd4;
  localparam logic [7:0] MODE_RESET = 8'd5;

  // per-channel command from the capture logic
  typedef struct packed {
    logic       tick;
    logic       load;
    logic [7:0] value;
  } chan_ctrl_t;

endpackage

// File: rtl/ssl_channel.sv
module ssl_channel
  import ssl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  chan_ctrl_t ctrl,
  output logic       led_nxt
);

  logic [7:0] mode_r, mode_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic       led_r;
  logic [7:0] cnt_dec;

  assign cnt_dec = cnt_r - 8'd1;

  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    led_nxt  = led_r;
    if (ctrl.load) begin
      mode_nxt = ctrl.value;
      cnt_nxt  = ctrl.value;
    end else if (ctrl.tick) begin
      if (mode_r < MODE_ON) begin
        if (cnt_dec == 8'd0) begin
          led_nxt = ~led_r;
          cnt_nxt = mode_r;
        end else begin
          cnt_nxt = cnt_dec;
        end
      end else if (mode_r == MODE_ON) begin
        led_nxt = 1'b1;
      end else begin
        led_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RESET;
      cnt_r  <= 8'd0;
      led_r  <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      led_r  <= led_nxt;
    end
  end

endmodule

// File: rtl/serial_set_led_blink_controller.sv
// LED blink controller set over a serial byte stream. Each input word is
// either a received byte (in_tuser = 0) or one timer tick (in_tuser = 1).
// A '*' byte toggles capture; while capturing, the next bytes set the modes
// of channel 0, 1, ... as (byte - 48), and capture closes after the last
// channel. On a tick, modes 0-3 count down and toggle the LED on reaching
// zero (mode 0 every 256 ticks), mode 4 holds the LED on, anything else off.
// Every input word yields one output word with the LED levels after that
// word. Rate: one word per cycle while in_tready is high; all channel
// updates are a single combinational step from the channel registers,
// and output and skid registers keep the input open while one result waits.
module serial_set_led_blink_controller
  import ssl_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  input  logic       in_tuser,   // [0] action
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] led0, [1] led1, [2] led2, [7:3] zero
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic             in_acc;
  logic             is_byte, is_star;
  logic             cap_r, cap_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       mode_val;
  logic [CHANNELS-1:0] led_vec;
  logic [OUT_LEDS-1:0] res;

  logic       out_valid_r, skid_valid_r;
  logic [7:0] out_data_r, skid_data_r;
  logic [7:0] res_word;

  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign is_byte   = in_acc && !in_tuser;
  assign is_star   = in_tdata == STAR_BYTE;
  assign mode_val  = in_tdata - DIGIT_BASE;

  always_comb begin
    cap_nxt = cap_r;
    idx_nxt = idx_r;
    if (is_byte) begin
      if (is_star) begin
        cap_nxt = ~cap_r;
        idx_nxt = '0;
      end else if (cap_r) begin
        if (idx_r == IDX_W'(CHANNELS - 1)) begin
          cap_nxt = 1'b0;
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= 1'b0;
      idx_r <= '0;
    end else begin
      cap_r <= cap_nxt;
      idx_r <= idx_nxt;
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    chan_ctrl_t ctrl;
    assign ctrl.tick  = in_acc && in_tuser;
    assign ctrl.load  = is_byte && !is_star && cap_r && (idx_r == IDX_W'(c));
    assign ctrl.value = mode_val;

    ssl_channel u_chan (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .led_nxt (led_vec[c])
    );
  end

  // channels beyond the count read as off
  for (genvar j = 0; j < OUT_LEDS; j++) begin : g_res
    if (j < CHANNELS) begin : g_on
      assign res[j] = led_vec[j];
    end else begin : g_off
      assign res[j] = 1'b0;
    end
  end

  assign res_word = {{(8 - OUT_LEDS){1'b0}}, res};

  // output register with skid word behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (in_acc) begin
        out_data_r <= res_word;
      end
    end else if (in_acc) begin
      skid_data_r <= res_word;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: rtl/ssl_checker.sv
`include "assert_macros.svh"

module ssl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  `ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result word dropped while stalled")
  `ASSERT_NEXT(a_acc_gives_out, in_tvalid && in_tready && !out_tvalid, out_tvalid, "accepted word produced no result")
  `ASSERT_NOW(a_pad_zero, out_tvalid, out_tdata[7:3] == 5'd0, "unused result bits not zero")
  `ASSERT_NEXT_ALWAYS(a_rst_empty, !rst_n, !out_tvalid, "result valid right after reset")

endmodule

bind serial_set_led_blink_controller ssl_checker u_ssl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
